// ===== rtl/tip_pkg.sv =====
// Shared constants, types and helpers of the table interpolation lookup block.
package tip_pkg;

    localparam int MAX_ENTRIES = 1024;
    localparam int VALUE_WIDTH = 32;
    localparam int FRAC_W      = 16;
    localparam int ADDR_W      = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int ROW_W       = 3 * VALUE_WIDTH;
    localparam int DIV_CNT_W   = $clog2(FRAC_W + 1);

    typedef logic [ADDR_W-1:0]                  addr_t;
    typedef logic [CNT_W-1:0]                   count_t;
    typedef logic signed [VALUE_WIDTH-1:0]      value_t;
    typedef logic signed [VALUE_WIDTH:0]        wide_t;
    typedef logic [FRAC_W:0]                    frac_t;
    typedef logic [FRAC_W-1:0]                  quot_t;
    typedef logic [DIV_CNT_W-1:0]               div_cnt_t;

    localparam count_t CNT_MIN = CNT_W'(2);
    localparam count_t CNT_MAX = CNT_W'(MAX_ENTRIES);
    // -1.0 in Q16.16
    localparam value_t KEY_LOW_LIMIT = VALUE_WIDTH'(-(64'sd1 <<< FRAC_W));
    localparam frac_t  FRAC_ONE      = {1'b1, {FRAC_W{1'b0}}};
    localparam div_cnt_t DIV_STEPS   = DIV_CNT_W'(FRAC_W);

    typedef enum logic {
        MODE_WRITE = 1'b0,
        MODE_QUERY = 1'b1
    } mode_t;

    typedef enum logic [1:0] {
        STATUS_INTERP = 2'd0,
        STATUS_BELOW  = 2'd1,
        STATUS_ABOVE  = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LAST_RD,
        S_LAST_CHK,
        S_MID,
        S_CMP,
        S_LO_RD,
        S_HI_RD,
        S_DIFF,
        S_FRAC,
        S_DIV,
        S_MUL_R,
        S_MUL_F,
        S_ADD_F,
        S_DONE
    } state_t;

    typedef struct packed {
        value_t key;
        value_t radius;
        value_t force_val;
    } row_t;

    function automatic count_t clamp_count(count_t v);
        count_t r;
        r = v;
        if (v < CNT_MIN)
            r = CNT_MIN;
        else if (v > CNT_MAX)
            r = CNT_MAX;
        return r;
    endfunction

endpackage

// ===== rtl/tip_if.sv =====
// Valid/ready stream interfaces for the input items and the result items.
interface tip_in_if;
    import tip_pkg::*;

    logic   valid;
    logic   ready;
    mode_t  mode;
    addr_t  entry_index;
    value_t key_value;
    value_t radius_value;
    value_t force_value;

    modport source (output valid, mode, entry_index, key_value, radius_value, force_value,
                    input ready);
    modport sink   (input valid, mode, entry_index, key_value, radius_value, force_value,
                    output ready);
endinterface

interface tip_out_if;
    import tip_pkg::*;

    logic    valid;
    logic    ready;
    value_t  radius_result;
    value_t  force_result;
    status_t status;
    logic    outside_seen;

    modport source (output valid, radius_result, force_result, status, outside_seen,
                    input ready);
    modport sink   (input valid, radius_result, force_result, status, outside_seen,
                    output ready);
endinterface

// ===== rtl/table_interpolation_lookup.sv =====
// Top level: table storage, binary search sequencer and shared fraction/multiply datapath.
// A write item produces no result. A query whose key lies above the last key in use or
// below -1.0 skips the search and goes straight to the result; otherwise it runs a binary
// search and, when the fraction needs one, a division. Each search step has a read state
// and a compare state because the key table has one registered read port; the fraction
// r/d comes from a divider that yields one quotient bit per cycle, and one 33x18 multiplier
// blends both columns in turn. The block takes no new item until the query's result has
// been loaded into the output register; a pending result may wait there while the next
// item is taken.
module table_interpolation_lookup (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  tip_pkg::count_t  cfg_data,
    tip_in_if.sink           in_ch,
    tip_out_if.source        out_ch
);
    import tip_pkg::*;

    state_t  state_reg, state_next;
    count_t  count_reg;
    logic    outside_reg;

    // query datapath
    value_t  key_reg;
    addr_t   lo_reg, hi_reg, last_reg, mid_reg;
    value_t  klo_reg, rlo_reg, flo_reg;
    wide_t   d_reg, r_reg, dr_reg, df_reg;
    frac_t   f_reg;
    value_t  prod_reg;
    value_t  ra_reg, fo_reg;
    status_t status_reg;

    // output register
    logic    out_valid_reg;
    value_t  out_radius_reg, out_force_reg;
    status_t out_status_reg;
    logic    out_outside_reg;

    // control
    logic    in_ready, in_xfer;
    logic    ram_we, ram_re;
    addr_t   ram_raddr;
    logic    div_start, out_load;

    logic [ROW_W-1:0] ram_rdata;
    row_t    rd_row, wr_row;
    count_t  count_m1;
    addr_t   last_idx;
    logic [ADDR_W:0] mid_sum;
    addr_t   mid_calc;
    logic    key_above, key_below;
    logic    d_pos, r_pos, r_ge_d;
    logic    div_busy, div_done;
    quot_t   div_quot;
    wide_t   mul_a;
    logic signed [FRAC_W+1:0]               mul_f;
    logic signed [VALUE_WIDTH+FRAC_W+1:0]   mul_full;

    assign rd_row    = row_t'(ram_rdata);
    assign wr_row    = '{key: in_ch.key_value, radius: in_ch.radius_value,
                         force_val: in_ch.force_value};
    assign count_m1  = count_reg - CNT_W'(1);
    assign last_idx  = count_m1[ADDR_W-1:0];
    assign mid_sum   = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid_calc  = mid_sum[ADDR_W:1];
    assign key_above = (key_reg > rd_row.key);
    assign key_below = (key_reg < KEY_LOW_LIMIT);
    assign d_pos     = (d_reg > wide_t'(0));
    assign r_pos     = (r_reg > wide_t'(0));
    assign r_ge_d    = (r_reg >= d_reg);
    assign in_xfer   = in_ch.valid && in_ready;

    // shared multiplier: column difference times fraction
    assign mul_a    = (state_reg == S_MUL_F) ? df_reg : dr_reg;
    assign mul_f    = signed'({1'b0, f_reg});
    assign mul_full = mul_a * mul_f;

    tip_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (in_ch.entry_index),
        .wdata (wr_row),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    tip_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (r_reg[VALUE_WIDTH-1:0]),
        .divisor  (d_reg[VALUE_WIDTH-1:0]),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quot)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer && in_ch.mode == MODE_QUERY)
                    state_next = S_LAST_RD;
            end
            S_LAST_RD:  state_next = S_LAST_CHK;
            S_LAST_CHK:
            begin
                if (key_above || key_below)
                    state_next = S_DONE;
                else
                    state_next = S_MID;
            end
            S_MID:
            begin
                if (mid_calc == last_reg)
                    state_next = S_LO_RD;
                else
                    state_next = S_CMP;
            end
            S_CMP:      state_next = S_MID;
            S_LO_RD:    state_next = S_HI_RD;
            S_HI_RD:    state_next = S_DIFF;
            S_DIFF:     state_next = S_FRAC;
            S_FRAC:
            begin
                if (!d_pos)
                    state_next = S_DONE;
                else if (!r_pos || r_ge_d)
                    state_next = S_MUL_R;
                else
                    state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                    state_next = S_MUL_R;
            end
            S_MUL_R:    state_next = S_MUL_F;
            S_MUL_F:    state_next = S_ADD_F;
            S_ADD_F:    state_next = S_DONE;
            S_DONE:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end
            default:    state_next = S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_ready  = 1'b0;
        ram_re    = 1'b0;
        ram_raddr = lo_reg;
        div_start = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            S_IDLE:    in_ready = 1'b1;
            S_LAST_RD:
            begin
                ram_re    = 1'b1;
                ram_raddr = last_idx;
            end
            S_MID:
            begin
                ram_re    = 1'b1;
                ram_raddr = mid_calc;
            end
            S_LO_RD:
            begin
                ram_re    = 1'b1;
                ram_raddr = lo_reg;
            end
            S_HI_RD:
            begin
                ram_re    = 1'b1;
                ram_raddr = hi_reg;
            end
            S_FRAC:    div_start = d_pos && r_pos && !r_ge_d && !div_busy;
            S_DONE:    out_load  = !out_valid_reg || out_ch.ready;
            default:   ;
        endcase
    end

    assign ram_we = in_xfer && (in_ch.mode == MODE_WRITE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= CNT_MAX;
            outside_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                count_reg <= clamp_count(cfg_data);
            if (state_reg == S_LAST_CHK && key_above)
                outside_reg <= 1'b1;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // query datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                    key_reg <= in_ch.key_value;
            end
            S_LAST_CHK:
            begin
                lo_reg   <= '0;
                hi_reg   <= last_idx;
                last_reg <= '0;
                ra_reg   <= '0;
                fo_reg   <= '0;
                // above is checked ahead of below
                if (key_above)
                    status_reg <= STATUS_ABOVE;
                else if (key_below)
                    status_reg <= STATUS_BELOW;
                else
                    status_reg <= STATUS_INTERP;
            end
            S_MID:     mid_reg <= mid_calc;
            S_CMP:
            begin
                if (key_reg < rd_row.key)
                    hi_reg <= mid_reg;
                else
                    lo_reg <= mid_reg;
                last_reg <= mid_reg;
            end
            S_HI_RD:
            begin
                klo_reg <= rd_row.key;
                rlo_reg <= rd_row.radius;
                flo_reg <= rd_row.force_val;
            end
            S_DIFF:
            begin
                d_reg  <= {rd_row.key[VALUE_WIDTH-1], rd_row.key}
                        - {klo_reg[VALUE_WIDTH-1], klo_reg};
                r_reg  <= {key_reg[VALUE_WIDTH-1], key_reg}
                        - {klo_reg[VALUE_WIDTH-1], klo_reg};
                dr_reg <= {rd_row.radius[VALUE_WIDTH-1], rd_row.radius}
                        - {rlo_reg[VALUE_WIDTH-1], rlo_reg};
                df_reg <= {rd_row.force_val[VALUE_WIDTH-1], rd_row.force_val}
                        - {flo_reg[VALUE_WIDTH-1], flo_reg};
            end
            S_FRAC:
            begin
                // equal or descending bracket keys give the lower entry
                if (!d_pos)
                begin
                    ra_reg <= rlo_reg;
                    fo_reg <= flo_reg;
                end
                else if (!r_pos)
                    f_reg <= '0;
                else if (r_ge_d)
                    f_reg <= FRAC_ONE;
            end
            S_DIV:
            begin
                if (div_done)
                    f_reg <= {1'b0, div_quot};
            end
            // a*(1-f) + b*f == a + (b-a)*f; floor of the shift is the arithmetic shift
            S_MUL_R:   prod_reg <= mul_full[VALUE_WIDTH+FRAC_W-1:FRAC_W];
            S_MUL_F:
            begin
                ra_reg   <= rlo_reg + prod_reg;
                prod_reg <= mul_full[VALUE_WIDTH+FRAC_W-1:FRAC_W];
            end
            S_ADD_F:   fo_reg <= flo_reg + prod_reg;
            default:   ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_radius_reg  <= ra_reg;
            out_force_reg   <= fo_reg;
            out_status_reg  <= status_reg;
            out_outside_reg <= outside_reg;
        end
    end

    assign in_ch.ready          = in_ready;
    assign out_ch.valid         = out_valid_reg;
    assign out_ch.radius_result = out_radius_reg;
    assign out_ch.force_result  = out_force_reg;
    assign out_ch.status        = out_status_reg;
    assign out_ch.outside_seen  = out_outside_reg;

`ifndef ASSERT_OFF
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg == STATUS_ABOVE) |-> out_outside_reg)
        else $error("above-range result without outside flag");

    assert property (@(posedge clk) disable iff (!rst_n)
        outside_reg |=> outside_reg)
        else $error("sticky outside flag cleared");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP) |-> (lo_reg <= mid_reg && mid_reg <= hi_reg))
        else $error("search midpoint outside bracket");
`endif

endmodule

// ===== rtl/tip_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module tip_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/tip_div.sv =====
// Restoring divider: one quotient bit per cycle of the Q0.16 fraction r/d, with r < d.
module tip_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [tip_pkg::VALUE_WIDTH-1:0]     dividend,
    input  logic [tip_pkg::VALUE_WIDTH-1:0]     divisor,
    output logic                                busy,
    output logic                                done,
    output tip_pkg::quot_t                      quotient
);
    import tip_pkg::*;

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    div_cnt_t               cnt_reg, cnt_next;
    logic [VALUE_WIDTH:0]   rem_reg, rem_next;
    logic [VALUE_WIDTH-1:0] dsr_reg;
    quot_t                  quo_reg, quo_next;

    logic [VALUE_WIDTH:0]   rem_sh;
    logic [VALUE_WIDTH:0]   dsr_ext;
    logic                   take;

    assign rem_sh  = {rem_reg[VALUE_WIDTH-1:0], 1'b0};
    assign dsr_ext = {1'b0, dsr_reg};
    assign take    = (rem_sh >= dsr_ext);

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_STEPS;
            rem_next  = {1'b0, dividend};
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = take ? (rem_sh - dsr_ext) : rem_sh;
            quo_next = {quo_reg[FRAC_W-2:0], take};
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
            dsr_reg <= divisor;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

`ifndef ASSERT_OFF
    // while busy, the partial remainder stays below the divisor
    assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (rem_reg < dsr_ext))
        else $error("divider remainder not below divisor");

    assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !start && cnt_reg == DIV_CNT_W'(1)) |=> (done_reg && !busy_reg))
        else $error("divider did not finish after last step");

    assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg)
        else $error("divider not busy after start");
`endif

endmodule

// ===== tb/sv/tb_table_interpolation_lookup.sv =====
// Self-checking testbench of the table interpolation lookup: directed table, random phases.
module tb_table_interpolation_lookup;
    timeunit 1ns;
    timeprecision 1ps;

    import tip_pkg::*;

    localparam int     SETTLE_CYCLES = 120;
    localparam int     QUIET_LIMIT   = 5000;
    localparam int     HOLD_CYCLES   = 400;
    localparam int     HEAVY_PCT     = 80;
    localparam int     MIXED_PCT     = 34;
    localparam longint Q_UNIT        = 64'sd65536;

    localparam value_t Q_ONE       = 32'sh0001_0000;
    localparam value_t Q_MINUS_ONE = 32'shFFFF_0000;
    localparam value_t V_MAX       = 32'sh7FFF_FFFF;
    localparam value_t V_MIN       = 32'sh8000_0000;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    typedef struct packed {
        mode_t  mode;
        addr_t  idx;
        value_t key;
        value_t radius;
        value_t force_val;
    } lookup_req_t;

    typedef struct packed {
        value_t  radius;
        value_t  force_val;
        status_t status;
        logic    outside;
    } lookup_res_t;

    typedef struct packed {
        lookup_req_t req;
        logic        typed;
        lookup_res_t res;
    } directed_row_t;

    typedef struct packed {
        count_t     cfg_value;
        count_t     rewrite;
        logic [9:0] items;
        idle_mode_t idle;
        logic       hold;
    } phase_t;

    localparam lookup_res_t NO_RES = '{32'sd0, 32'sd0, STATUS_INTERP, 1'b0};

    // Two-entry table; count register saturated to its floor before this runs.
    localparam directed_row_t DIRECTED_ROWS [20] = '{
        '{'{MODE_WRITE, 10'd0, Q_MINUS_ONE, V_MAX, V_MIN}, 1'b0, NO_RES},
        '{'{MODE_WRITE, 10'd1, Q_ONE, V_MIN, V_MAX}, 1'b0, NO_RES},
        '{'{MODE_QUERY, 10'd0, V_MIN, 32'sd0, 32'sd0}, 1'b1,
          '{32'sd0, 32'sd0, STATUS_BELOW, 1'b0}},
        '{'{MODE_QUERY, 10'd0, 32'shFFFE_FFFF, 32'sd0, 32'sd0}, 1'b1,
          '{32'sd0, 32'sd0, STATUS_BELOW, 1'b0}},
        '{'{MODE_QUERY, 10'd1, Q_MINUS_ONE, 32'sd0, 32'sd0}, 1'b1,
          '{V_MAX, V_MIN, STATUS_INTERP, 1'b0}},
        '{'{MODE_QUERY, 10'd0, Q_ONE, 32'sd0, 32'sd0}, 1'b1,
          '{V_MIN, V_MAX, STATUS_INTERP, 1'b0}},
        '{'{MODE_QUERY, 10'd0, 32'sd0, 32'sd0, 32'sd0}, 1'b0, NO_RES},
        '{'{MODE_QUERY, 10'd0, 32'sh0001_0001, 32'sd0, 32'sd0}, 1'b1,
          '{32'sd0, 32'sd0, STATUS_ABOVE, 1'b1}},
        '{'{MODE_QUERY, 10'h3FF, V_MAX, V_MAX, V_MAX}, 1'b1,
          '{32'sd0, 32'sd0, STATUS_ABOVE, 1'b1}},
        '{'{MODE_QUERY, 10'd0, 32'sh0000_4000, 32'sd0, 32'sd0}, 1'b0, NO_RES},
        // duplicate keys: lower entry wins
        '{'{MODE_WRITE, 10'd1, Q_MINUS_ONE, 32'sd5, -32'sd5}, 1'b0, NO_RES},
        '{'{MODE_QUERY, 10'd0, Q_MINUS_ONE, 32'sd0, 32'sd0}, 1'b1,
          '{V_MAX, V_MIN, STATUS_INTERP, 1'b1}},
        // descending keys
        '{'{MODE_WRITE, 10'd0, 32'sh0002_0000, 32'sh1234_5678, 32'shEDCB_A988}, 1'b0, NO_RES},
        '{'{MODE_QUERY, 10'd0, Q_MINUS_ONE, 32'sd0, 32'sd0}, 1'b0, NO_RES},
        '{'{MODE_QUERY, 10'd0, 32'shFFFF_8000, 32'sd0, 32'sd0}, 1'b1,
          '{32'sd0, 32'sd0, STATUS_ABOVE, 1'b1}},
        // key below the first entry but not below -1.0: fraction clamps at zero
        '{'{MODE_WRITE, 10'd0, 32'sh0000_8000, 32'sd7, 32'shA5A5_5A5A}, 1'b0, NO_RES},
        '{'{MODE_WRITE, 10'd1, 32'sh0003_0000, -32'sd3, 32'sh5A5A_A5A5}, 1'b0, NO_RES},
        '{'{MODE_QUERY, 10'd0, 32'sd0, 32'sd0, 32'sd0}, 1'b1,
          '{32'sd7, 32'shA5A5_5A5A, STATUS_INTERP, 1'b1}},
        '{'{MODE_QUERY, 10'd0, 32'sh0001_8000, 32'sd0, 32'sd0}, 1'b0, NO_RES},
        '{'{MODE_QUERY, 10'd0, 32'sh0003_0000, 32'sd0, 32'sd0}, 1'b1,
          '{-32'sd3, 32'sh5A5A_A5A5, STATUS_INTERP, 1'b1}}
    };

    localparam phase_t PHASES [6] = '{
        '{11'd96,   11'd96,   10'd70,  IDLE_NONE,     1'b0},
        '{11'd1,    11'd2,    10'd60,  IDLE_SENDER,   1'b0},
        '{11'd37,   11'd37,   10'd80,  IDLE_RECEIVER, 1'b1},
        '{11'd64,   11'd16,   10'd70,  IDLE_BOTH,     1'b0},
        '{11'd2,    11'd2,    10'd40,  IDLE_RECEIVER, 1'b0},
        '{11'd96,   11'd0,    10'd50,  IDLE_SENDER,   1'b0}
    };

    logic   clk;
    logic   rst_n;
    logic   cfg_we;
    count_t cfg_data;

    tip_in_if  in_ch ();
    tip_out_if out_ch ();

    table_interpolation_lookup u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .in_ch    (in_ch),
        .out_ch   (out_ch)
    );

    // mirror of the block's table and flags
    value_t key_mem    [MAX_ENTRIES];
    value_t radius_mem [MAX_ENTRIES];
    value_t force_mem  [MAX_ENTRIES];
    logic   outside_state;
    int     active_count;

    lookup_res_t expected_lookups [$];
    int          error_count;
    int          src_idle_pct;
    int          sink_stall_pct;
    int          hold_requests;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic longint rand_between(longint lo, longint hi);
        longint unsigned span;
        longint unsigned u;
        if (hi <= lo)
            return lo;
        span = longint'(hi - lo) + 1;
        u = {$urandom, $urandom};
        return lo + longint'(u % span);
    endfunction

    function automatic value_t rand_value();
        case ($urandom_range(7))
            0: return V_MAX;
            1: return V_MIN;
            default: return value_t'($urandom);
        endcase
    endfunction

    function automatic longint blend_q16(longint a, longint b, longint f);
        // arithmetic shift floors toward minus infinity
        return (a * (Q_UNIT - f) + b * f) >>> 16;
    endfunction

    // Applies one accepted item to the mirror; returns 1 when a result follows.
    function automatic logic lookup_step(input lookup_req_t req, output lookup_res_t res);
        longint key;
        longint span_k;
        longint offs;
        longint frac;
        int     low_ix;
        int     high_ix;
        int     mid_ix;
        int     prev_ix;
        res = NO_RES;
        key = req.key;
        if (req.mode == MODE_WRITE)
        begin
            key_mem[req.idx]    = req.key;
            radius_mem[req.idx] = req.radius;
            force_mem[req.idx]  = req.force_val;
            return 1'b0;
        end
        if (key > longint'(key_mem[active_count-1]))
        begin
            res.status = STATUS_ABOVE;
            outside_state = 1'b1;
        end
        else if (key < longint'(KEY_LOW_LIMIT))
        begin
            res.status = STATUS_BELOW;
        end
        else
        begin
            low_ix = 0;
            high_ix = active_count - 1;
            prev_ix = 0;
            for (int step = 0; step < 64; step++)
            begin
                mid_ix = (low_ix + high_ix) / 2;
                if (mid_ix == prev_ix)
                    break;
                if (key < longint'(key_mem[mid_ix]))
                    high_ix = mid_ix;
                else
                    low_ix = mid_ix;
                prev_ix = mid_ix;
            end
            span_k = longint'(key_mem[high_ix]) - longint'(key_mem[low_ix]);
            offs = key - longint'(key_mem[low_ix]);
            if (span_k <= 0)
            begin
                res.radius    = radius_mem[low_ix];
                res.force_val = force_mem[low_ix];
            end
            else
            begin
                if (offs <= 0)
                    frac = 0;
                else if (offs >= span_k)
                    frac = Q_UNIT;
                else
                    frac = (offs * Q_UNIT) / span_k;
                res.radius    = value_t'(blend_q16(radius_mem[low_ix], radius_mem[high_ix],
                                                   frac));
                res.force_val = value_t'(blend_q16(force_mem[low_ix], force_mem[high_ix],
                                                   frac));
            end
            res.status = STATUS_INTERP;
        end
        res.outside = outside_state;
        return 1'b1;
    endfunction

    // Mostly order-preserving writes and queries aimed at the table's brackets.
    function automatic lookup_req_t random_item(int n);
        lookup_req_t req;
        int          i;
        int          pick;
        longint      lo_k;
        longint      hi_k;
        longint      last_k;
        req.idx       = addr_t'($urandom_range(n - 1));
        req.key       = value_t'($urandom);
        req.radius    = rand_value();
        req.force_val = rand_value();
        i = int'(req.idx);
        pick = $urandom_range(99);
        last_k = key_mem[n-1];
        if ($urandom_range(99) < 40)
        begin
            req.mode = MODE_WRITE;
            lo_k = (i > 0) ? longint'(key_mem[i-1]) : longint'(key_mem[i]) - Q_UNIT;
            hi_k = (i < n - 1) ? longint'(key_mem[i+1]) : longint'(key_mem[i]) + Q_UNIT;
            if (lo_k < longint'(V_MIN))
                lo_k = V_MIN;
            if (hi_k > longint'(V_MAX))
                hi_k = V_MAX;
            if (pick < 85 && lo_k <= hi_k)
                req.key = value_t'(rand_between(lo_k, hi_k));
        end
        else
        begin
            req.mode = MODE_QUERY;
            i = $urandom_range(n - 2);
            if (pick < 45 && key_mem[i] <= key_mem[i+1])
                req.key = value_t'(rand_between(key_mem[i], key_mem[i+1]));
            else if (pick < 60)
                req.key = key_mem[$urandom_range(n - 1)];
            else if (pick < 70)
                req.key = value_t'(rand_between(V_MIN, longint'(KEY_LOW_LIMIT) - 1));
            else if (pick < 80 && last_k < longint'(V_MAX))
                req.key = value_t'(rand_between(last_k + 1, V_MAX));
            else if (pick < 90)
                req.key = value_t'(rand_between(KEY_LOW_LIMIT, key_mem[0]));
        end
        return req;
    endfunction

    task automatic write_config(input count_t value);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (value < CNT_MIN)
            active_count = CNT_MIN;
        else if (value > CNT_MAX)
            active_count = CNT_MAX;
        else
            active_count = value;
    endtask

    task automatic send_item(input lookup_req_t req, input logic typed,
                             input lookup_res_t typed_res);
        lookup_res_t res;
        if ($urandom_range(99) < src_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < src_idle_pct);
        end
        in_ch.valid        <= 1'b1;
        in_ch.mode         <= req.mode;
        in_ch.entry_index  <= req.idx;
        in_ch.key_value    <= req.key;
        in_ch.radius_value <= req.radius;
        in_ch.force_value  <= req.force_val;
        do
            @(posedge clk);
        while (!in_ch.ready);
        // transfer done at this edge
        if (lookup_step(req, res))
            expected_lookups.push_back(typed ? typed_res : res);
    endtask

    task automatic settle();
        while (expected_lookups.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // result side: checks every transfer, drives ready with stalls and hold-offs
    initial
    begin
        lookup_res_t want;
        int          hold_left;
        int          hold_seen;
        hold_left = 0;
        hold_seen = 0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_lookups.size() == 0)
                begin
                    $error("unexpected result: radius %h force %h status %0d outside %b",
                           out_ch.radius_result, out_ch.force_result, out_ch.status,
                           out_ch.outside_seen);
                    error_count++;
                end
                else
                begin
                    want = expected_lookups.pop_front();
                    if (out_ch.radius_result !== want.radius)
                    begin
                        $error("radius_result: expected %h, actual %h",
                               want.radius, out_ch.radius_result);
                        error_count++;
                    end
                    if (out_ch.force_result !== want.force_val)
                    begin
                        $error("force_result: expected %h, actual %h",
                               want.force_val, out_ch.force_result);
                        error_count++;
                    end
                    if (out_ch.status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, out_ch.status);
                        error_count++;
                    end
                    if (out_ch.outside_seen !== want.outside)
                    begin
                        $error("outside_seen: expected %b, actual %b",
                               want.outside, out_ch.outside_seen);
                        error_count++;
                    end
                end
            end
            if (hold_seen != hold_requests)
            begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    // ends the run when no transfer happens on either side for too long
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL table_interpolation_lookup");
        $finish;
    end

    initial
    begin
        lookup_req_t req;
        phase_t      ph;
        longint      key_acc;
        longint      max_step;
        error_count    = 0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_requests  = 0;
        outside_state  = 1'b0;
        active_count   = MAX_ENTRIES;
        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_data           <= '0;
        in_ch.valid        <= 1'b0;
        in_ch.mode         <= MODE_WRITE;
        in_ch.entry_index  <= '0;
        in_ch.key_value    <= '0;
        in_ch.radius_value <= '0;
        in_ch.force_value  <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_config(11'd0);
        foreach (DIRECTED_ROWS[i])
            send_item(DIRECTED_ROWS[i].req, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].res);
        in_ch.valid <= 1'b0;

        foreach (PHASES[p])
        begin
            ph = PHASES[p];
            settle();
            write_config(ph.cfg_value);
            src_idle_pct   = (ph.idle == IDLE_SENDER) ? HEAVY_PCT :
                             (ph.idle == IDLE_BOTH) ? MIXED_PCT : 0;
            sink_stall_pct = (ph.idle == IDLE_RECEIVER) ? HEAVY_PCT :
                             (ph.idle == IDLE_BOTH) ? MIXED_PCT : 0;
            if (ph.hold)
                hold_requests++;
            // ascending keys with a few duplicates, scale varies per phase
            if (ph.rewrite != 0)
            begin
                key_acc = ($urandom_range(1) == 0) ? rand_between(-4 * Q_UNIT, Q_UNIT)
                                                   : rand_between(-(64'sd1 << 30), 64'sd1 << 18);
                max_step = ((64'sd1 << 30) / ph.rewrite) >>> $urandom_range(12);
                if (max_step < 1)
                    max_step = 1;
                for (int i = 0; i < ph.rewrite; i++)
                begin
                    req.mode      = MODE_WRITE;
                    req.idx       = addr_t'(i);
                    req.key       = value_t'(key_acc);
                    req.radius    = rand_value();
                    req.force_val = rand_value();
                    send_item(req, 1'b0, NO_RES);
                    if ($urandom_range(15) != 0)
                        key_acc += rand_between(1, max_step);
                end
            end
            for (int i = 0; i < ph.items; i++)
                send_item(random_item(active_count), 1'b0, NO_RES);
            in_ch.valid <= 1'b0;
        end

        settle();
        if (error_count == 0 && expected_lookups.size() == 0)
            $display("PASS table_interpolation_lookup");
        else
            $display("FAIL table_interpolation_lookup");
        $finish;
    end

endmodule
